@@ rtl/bpfdc_pkg.sv @@
// shared types and constants of the packet buffer with duplicate filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bpfdc_pkg;

  localparam int ID_W     = 16;
  localparam int TIME_W   = 32;
  localparam int OP_W     = 2;
  localparam int LIMIT_W  = 7;
  localparam int COUNT_W  = 7;
  localparam int ENTRY_W  = 2 * ID_W + TIME_W;

  localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
  localparam logic [OP_W-1:0] OP_FORWARD = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT   = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_FWD,
    KIND_CNT,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   src;
    logic [ID_W-1:0]   dst;
    logic [TIME_W-1:0] ts;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/bpfdc_if.sv @@
// valid/ready channel interfaces for commands and responses
// depends on bpfdc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bpfdc_in_if;
  logic                          valid;
  logic                          ready;
  logic [bpfdc_pkg::OP_W-1:0]    opcode;
  logic [bpfdc_pkg::ID_W-1:0]    source_id;
  logic [bpfdc_pkg::ID_W-1:0]    destination;
  logic [bpfdc_pkg::TIME_W-1:0]  timestamp;
  logic [bpfdc_pkg::TIME_W-1:0]  start_time;
  logic [bpfdc_pkg::TIME_W-1:0]  end_time;

  modport source (output valid, opcode, source_id, destination, timestamp, start_time,
                  end_time, input ready);
  modport sink (input valid, opcode, source_id, destination, timestamp, start_time,
                end_time, output ready);
endinterface

interface bpfdc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [bpfdc_pkg::ID_W-1:0]    out_source;
  logic [bpfdc_pkg::ID_W-1:0]    out_destination;
  logic [bpfdc_pkg::TIME_W-1:0]  out_timestamp;
  logic [bpfdc_pkg::COUNT_W-1:0] match_count;

  modport source (output valid, ok, out_source, out_destination, out_timestamp,
                  match_count, input ready);
  modport sink (input valid, ok, out_source, out_destination, out_timestamp,
                match_count, output ready);
endinterface

`default_nettype wire

@@ rtl/bpfdc_front.sv @@
// front end: accepts commands, decodes the opcode, two-entry command queue
// depends on bpfdc_pkg and bpfdc_if
`timescale 1ns / 1ps
`default_nettype none

module bpfdc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  bpfdc_in_if.sink             cmd,
  output bpfdc_pkg::cmd_t      q_data,
  output logic                 q_valid,
  input  wire logic            q_ready
);

  localparam int DEPTH = 2;

  bpfdc_pkg::cmd_t q [DEPTH];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  bpfdc_pkg::cmd_t decoded;
  logic            push;
  logic            pop;

  always_comb begin
    decoded.src = cmd.source_id;
    decoded.dst = cmd.destination;
    decoded.ts  = cmd.timestamp;
    decoded.lo  = cmd.start_time;
    decoded.hi  = cmd.end_time;
    case (cmd.opcode)
      bpfdc_pkg::OP_ADD:     decoded.kind = bpfdc_pkg::KIND_ADD;
      bpfdc_pkg::OP_FORWARD: decoded.kind = bpfdc_pkg::KIND_FWD;
      bpfdc_pkg::OP_COUNT:   decoded.kind = bpfdc_pkg::KIND_CNT;
      default:               decoded.kind = bpfdc_pkg::KIND_NOP;
    endcase
  end

  assign cmd.ready = (fill != 2'(DEPTH));
  assign q_valid   = (fill != 2'd0);
  assign q_data    = q[rd_ptr];
  assign push      = cmd.valid && cmd.ready;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/bpfdc_back.sv @@
// back end: entry ring memory, slot walk sequencer and response register
// depends on bpfdc_pkg and bpfdc_if
`timescale 1ns / 1ps
`default_nettype none

module bpfdc_back #(
  parameter int CAPACITY = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire bpfdc_pkg::cmd_t                 q_data,
  input  wire logic                            q_valid,
  output logic                                 q_ready,
  input  wire logic [bpfdc_pkg::LIMIT_W-1:0]   limit,
  output logic [$clog2(CAPACITY+1)-1:0]        held,
  bpfdc_out_if.source                          rsp
);

  localparam int HW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SW = HW + 1;
  localparam int LW = (HW > bpfdc_pkg::LIMIT_W) ? HW : bpfdc_pkg::LIMIT_W;

  logic [bpfdc_pkg::ENTRY_W-1:0] mem [CAPACITY];

  bpfdc_pkg::state_t               state;
  bpfdc_pkg::state_t               state_next;
  bpfdc_pkg::cmd_t                 cur;
  logic [HW-1:0]                   idx;
  logic [HW-1:0]                   scan_len;
  logic                            rd_pend;
  logic [bpfdc_pkg::ENTRY_W-1:0]   rd_data;
  logic                            dup;
  logic [bpfdc_pkg::COUNT_W-1:0]   cnt;
  logic [AW-1:0]                   oldest;

  logic                            take;
  logic                            issue;
  logic                            scan_end;
  logic                            finish;
  logic [SW-1:0]                   scan_sum;
  logic [SW-1:0]                   tail_sum;
  logic [AW-1:0]                   scan_addr;
  logic [AW-1:0]                   tail_addr;
  logic [AW-1:0]                   oldest_inc;
  logic [LW-1:0]                   lim_w;
  logic [LW-1:0]                   eff_limit;
  logic                            at_limit;
  logic                            hit_dup;
  logic                            hit_cnt;
  logic                            add_ok;
  logic [bpfdc_pkg::ID_W-1:0]      rd_src;
  logic [bpfdc_pkg::ID_W-1:0]      rd_dst;
  logic [bpfdc_pkg::TIME_W-1:0]    rd_ts;

  // ring address arithmetic, sums stay below twice the capacity
  always_comb begin
    scan_sum = SW'(oldest) + SW'(idx);
    if (scan_sum >= SW'(CAPACITY)) begin
      scan_sum = scan_sum - SW'(CAPACITY);
    end
    tail_sum = SW'(oldest) + SW'(held);
    if (tail_sum >= SW'(CAPACITY)) begin
      tail_sum = tail_sum - SW'(CAPACITY);
    end
  end

  assign scan_addr  = scan_sum[AW-1:0];
  assign tail_addr  = tail_sum[AW-1:0];
  assign oldest_inc = (oldest == AW'(CAPACITY - 1)) ? '0 : oldest + AW'(1);

  // limit of zero acts as one, above capacity saturates
  always_comb begin
    lim_w = LW'(limit);
    if (limit == '0) begin
      eff_limit = LW'(1);
    end else if (lim_w > LW'(CAPACITY)) begin
      eff_limit = LW'(CAPACITY);
    end else begin
      eff_limit = lim_w;
    end
  end

  assign at_limit = (LW'(held) >= eff_limit);

  assign rd_src  = rd_data[bpfdc_pkg::ENTRY_W-1 -: bpfdc_pkg::ID_W];
  assign rd_dst  = rd_data[bpfdc_pkg::TIME_W +: bpfdc_pkg::ID_W];
  assign rd_ts   = rd_data[bpfdc_pkg::TIME_W-1:0];
  assign hit_dup = (rd_src == cur.src) && (rd_dst == cur.dst) && (rd_ts == cur.ts);
  assign hit_cnt = (rd_dst == cur.dst) && (rd_ts >= cur.lo) && (rd_ts <= cur.hi);
  assign add_ok  = (cur.kind == bpfdc_pkg::KIND_ADD) && !dup;

  always_comb begin
    state_next = state;
    case (state)
      bpfdc_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = bpfdc_pkg::ST_SCAN;
        end
      end
      bpfdc_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = bpfdc_pkg::ST_DONE;
        end
      end
      bpfdc_pkg::ST_DONE: begin
        if (finish) begin
          state_next = bpfdc_pkg::ST_IDLE;
        end
      end
      default: state_next = bpfdc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready  = 1'b0;
    issue    = 1'b0;
    scan_end = 1'b0;
    finish   = 1'b0;
    case (state)
      bpfdc_pkg::ST_IDLE: q_ready = 1'b1;
      bpfdc_pkg::ST_SCAN: begin
        issue    = (idx < scan_len);
        scan_end = (idx == scan_len) && !rd_pend;
      end
      bpfdc_pkg::ST_DONE: finish = !rsp.valid || rsp.ready;
      default: q_ready = 1'b0;
    endcase
  end

  assign take = q_ready && q_valid;

  // entry memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (finish && add_ok) begin
      mem[tail_addr] <= {cur.src, cur.dst, cur.ts};
    end
    if (issue) begin
      rd_data <= mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_data;
      idx <= '0;
      dup <= 1'b0;
      cnt <= '0;
      case (q_data.kind)
        bpfdc_pkg::KIND_ADD: scan_len <= held;
        bpfdc_pkg::KIND_CNT: scan_len <= held;
        bpfdc_pkg::KIND_FWD: scan_len <= (held != '0) ? HW'(1) : '0;
        default:             scan_len <= '0;
      endcase
    end else begin
      if (issue) begin
        idx <= idx + HW'(1);
      end
      if (rd_pend) begin
        if (hit_dup) begin
          dup <= 1'b1;
        end
        if (hit_cnt && cnt != bpfdc_pkg::COUNT_MAX) begin
          cnt <= cnt + bpfdc_pkg::COUNT_W'(1);
        end
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.ok              <= 1'b0;
      rsp.out_source      <= '0;
      rsp.out_destination <= '0;
      rsp.out_timestamp   <= '0;
      rsp.match_count     <= '0;
      case (cur.kind)
        bpfdc_pkg::KIND_ADD: rsp.ok <= !dup;
        bpfdc_pkg::KIND_FWD: begin
          if (held != '0) begin
            rsp.ok              <= 1'b1;
            rsp.out_source      <= rd_src;
            rsp.out_destination <= rd_dst;
            rsp.out_timestamp   <= rd_ts;
          end
        end
        bpfdc_pkg::KIND_CNT: rsp.match_count <= cnt;
        default: rsp.ok <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpfdc_pkg::ST_IDLE;
      rd_pend   <= 1'b0;
      oldest    <= '0;
      held      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (finish) begin
        rsp.valid <= 1'b1;
        if (add_ok) begin
          if (at_limit) begin
            oldest <= oldest_inc;
          end else begin
            held <= held + HW'(1);
          end
        end else if (cur.kind == bpfdc_pkg::KIND_FWD && held != '0) begin
          oldest <= oldest_inc;
          held   <= held - HW'(1);
        end
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/bounded_packet_fifo_dedup_count.sv @@
// Packet buffer holding up to memory_limit (source, destination, timestamp)
// entries in arrival order, with a duplicate filter on add, pop of the
// oldest entry on forward, and a count of held entries matching a
// destination and inclusive time window. Each command gives one response.
// Add and count walk every held entry through the single read port of the
// entry memory, one slot per cycle; forward reads only the oldest entry
// and unused opcodes read none. A two-entry command queue in front accepts
// new commands while one is being worked on, and a response register holds
// the finished result until it is taken. The user must write memory_limit
// via cfg_we/cfg_data only while the buffer is empty; the block does not enforce it.
// depends on bpfdc_pkg, bpfdc_if, bpfdc_front and bpfdc_back
`timescale 1ns / 1ps
`default_nettype none

module bounded_packet_fifo_dedup_count #(
  parameter int CAPACITY = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  bpfdc_in_if.sink                           cmd,
  bpfdc_out_if.source                        rsp,
  input  wire logic                          cfg_we,
  input  wire logic [bpfdc_pkg::LIMIT_W-1:0] cfg_data
);

  localparam int HW = $clog2(CAPACITY + 1);

  logic [bpfdc_pkg::LIMIT_W-1:0] limit;
  bpfdc_pkg::cmd_t               q_data;
  logic                          q_valid;
  logic                          q_ready;
  logic [HW-1:0]                 held;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= bpfdc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

  bpfdc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  bpfdc_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .limit   (limit),
    .held    (held),
    .rsp     (rsp)
  );

  // occupancy never exceeds the ring
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    int'(held) <= CAPACITY)
    else $error("held count above capacity");

  // occupancy moves by at most one per transfer
  a_held_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (held == $past(held) || int'(held) == int'($past(held)) + 1 ||
                     int'(held) == int'($past(held)) - 1))
    else $error("held count jumped");

  // a response never carries both an accept and a match count
  a_rsp_kind: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.ok && rsp.match_count != '0))
    else $error("response mixes ok and count");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// self-checking bench for bounded_packet_fifo_dedup_count: directed table, then random traffic
// keeps its own copy of the buffer to predict each response; needs bpfdc_pkg, bpfdc_if and the rtl
`timescale 1ns / 1ps

module testbench;

  localparam int OP_W    = bpfdc_pkg::OP_W;
  localparam int ID_W    = bpfdc_pkg::ID_W;
  localparam int TIME_W  = bpfdc_pkg::TIME_W;
  localparam int LIMIT_W = bpfdc_pkg::LIMIT_W;
  localparam int COUNT_W = bpfdc_pkg::COUNT_W;
  localparam logic [OP_W-1:0]    OP_ADD      = bpfdc_pkg::OP_ADD;
  localparam logic [OP_W-1:0]    OP_FORWARD  = bpfdc_pkg::OP_FORWARD;
  localparam logic [OP_W-1:0]    OP_COUNT    = bpfdc_pkg::OP_COUNT;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = bpfdc_pkg::LIMIT_RESET;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = bpfdc_pkg::COUNT_MAX;

  localparam int DEPTH = 64;
  localparam int SEG_ITEMS = 145;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   src;
    logic [ID_W-1:0]   dst;
    logic [TIME_W-1:0] ts;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
  } command_t;

  typedef struct packed {
    logic [ID_W-1:0]   src;
    logic [ID_W-1:0]   dst;
    logic [TIME_W-1:0] ts;
  } packet_t;

  typedef struct packed {
    logic               ok;
    logic [ID_W-1:0]    src;
    logic [ID_W-1:0]    dst;
    logic [TIME_W-1:0]  ts;
    logic [COUNT_W-1:0] cnt;
  } response_t;

  typedef enum logic {ROW_CMD, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [LIMIT_W-1:0] lim;
    command_t           c;
    logic               typed;
    response_t          want;
  } directed_row_t;

  localparam response_t NONE     = '0;
  localparam response_t ACCEPTED = '{1'b1, 16'h0000, 16'h0000, 32'h0000_0000, 7'd0};

  localparam int N_DIRECTED = 25;
  directed_row_t directed [N_DIRECTED] = '{
    '{ROW_CMD, 7'd0, '{OP_FORWARD, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0, 32'h0},
      1'b1, NONE},
    '{ROW_CMD, 7'd0, '{OP_COUNT, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0, 32'hffff_ffff},
      1'b1, NONE},
    '{ROW_CMD, 7'd0, '{OP_UNUSED, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff,
      32'hffff_ffff}, 1'b1, NONE},
    '{ROW_CMD, 7'd0, '{OP_ADD, 16'hffff, 16'hffff, 32'hffff_ffff, 32'h0, 32'h0},
      1'b1, ACCEPTED},
    '{ROW_CMD, 7'd0, '{OP_ADD, 16'hffff, 16'hffff, 32'hffff_ffff, 32'h0, 32'h0},
      1'b1, NONE},
    '{ROW_CMD, 7'd0, '{OP_ADD, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0, 32'h0},
      1'b1, ACCEPTED},
    '{ROW_CMD, 7'd0, '{OP_ADD, 16'hffff, 16'hffff, 32'hffff_fffe, 32'h0, 32'h0},
      1'b1, ACCEPTED},
    '{ROW_CMD, 7'd0, '{OP_ADD, 16'hfffe, 16'hffff, 32'hffff_ffff, 32'h0, 32'h0},
      1'b1, ACCEPTED},
    '{ROW_CMD, 7'd0, '{OP_ADD, 16'h0000, 16'hffff, 32'h0000_0000, 32'h0, 32'h0},
      1'b0, NONE},
    '{ROW_CMD, 7'd0, '{OP_COUNT, 16'h0000, 16'hffff, 32'h0, 32'h0000_0000, 32'hffff_ffff},
      1'b0, NONE},
    '{ROW_CMD, 7'd0, '{OP_COUNT, 16'h0000, 16'hffff, 32'h0, 32'hffff_ffff, 32'hffff_ffff},
      1'b1, '{1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 7'd2}},
    '{ROW_CMD, 7'd0, '{OP_COUNT, 16'h0000, 16'hffff, 32'h0, 32'hffff_ffff, 32'h0000_0000},
      1'b1, NONE},
    '{ROW_CMD, 7'd0, '{OP_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h0000_0000, 32'h0000_0000},
      1'b1, '{1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 7'd1}},
    '{ROW_CMD, 7'd0, '{OP_UNUSED, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0},
      1'b1, NONE},
    '{ROW_CMD, 7'd0, '{OP_FORWARD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0},
      1'b1, '{1'b1, 16'hffff, 16'hffff, 32'hffff_ffff, 7'd0}},
    '{ROW_CMD, 7'd0, '{OP_FORWARD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0},
      1'b1, ACCEPTED},
    '{ROW_CMD, 7'd0, '{OP_FORWARD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0},
      1'b0, NONE},
    '{ROW_CMD, 7'd0, '{OP_FORWARD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0},
      1'b0, NONE},
    '{ROW_CMD, 7'd0, '{OP_FORWARD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0},
      1'b0, NONE},
    '{ROW_CMD, 7'd0, '{OP_FORWARD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0},
      1'b1, NONE},
    '{ROW_LIMIT, 7'd0, '{OP_FORWARD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0},
      1'b0, NONE},
    '{ROW_CMD, 7'd0, '{OP_ADD, 16'h1234, 16'h5678, 32'h0000_0001, 32'h0, 32'h0},
      1'b1, ACCEPTED},
    '{ROW_CMD, 7'd0, '{OP_ADD, 16'h1234, 16'h5678, 32'h0000_0002, 32'h0, 32'h0},
      1'b1, ACCEPTED},
    '{ROW_CMD, 7'd0, '{OP_FORWARD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0},
      1'b1, '{1'b1, 16'h1234, 16'h5678, 32'h0000_0002, 7'd0}},
    '{ROW_CMD, 7'd0, '{OP_FORWARD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0},
      1'b1, NONE}
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic [LIMIT_W-1:0] cfg_data;

  bpfdc_in_if  cmd_bus ();
  bpfdc_out_if rsp_bus ();

  bounded_packet_fifo_dedup_count #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .rsp(rsp_bus),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  packet_t held_q[$];
  response_t pending[$];
  logic [LIMIT_W-1:0] limit_reg;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned responses_seen;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic int unsigned effective_limit();
    if (limit_reg == '0) return 1;
    if (limit_reg > DEPTH) return DEPTH;
    return limit_reg;
  endfunction

  // applies one command to the buffer copy and returns the response it gives
  function automatic response_t advance_buffer(command_t c);
    response_t r;
    packet_t p;
    logic dup;
    r = '0;
    dup = 1'b0;
    case (c.op)
      OP_ADD: begin
        p = '{c.src, c.dst, c.ts};
        foreach (held_q[i]) if (held_q[i] == p) dup = 1'b1;
        if (!dup) begin
          if (held_q.size() >= effective_limit()) void'(held_q.pop_front());
          held_q.push_back(p);
          r.ok = 1'b1;
        end
      end
      OP_FORWARD: begin
        if (held_q.size() != 0) begin
          p = held_q.pop_front();
          r = '{1'b1, p.src, p.dst, p.ts, 7'd0};
        end
      end
      OP_COUNT: begin
        foreach (held_q[i]) begin
          if (held_q[i].dst == c.dst && held_q[i].ts >= c.lo && held_q[i].ts <= c.hi &&
              r.cnt < COUNT_MAX) begin
            r.cnt = r.cnt + 7'd1;
          end
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hffff;
      2, 3, 4: return 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2, 3, 4: return 32'($urandom_range(15));
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic command_t random_command(int unsigned fwd_pct);
    command_t c;
    packet_t p;
    int unsigned r;
    c = '{OP_ADD, 16'($urandom), 16'($urandom), 32'($urandom), 32'($urandom),
          32'($urandom)};
    r = $urandom_range(99);
    if (held_q.size() != 0) p = held_q[$urandom_range(held_q.size() - 1)];
    else p = '{pick_id(), pick_id(), pick_time()};
    if (r < fwd_pct) begin
      c.op = OP_FORWARD;
    end else if (r < fwd_pct + 5) begin
      c.op = OP_UNUSED;
    end else if (r < fwd_pct + 36) begin
      c.op = OP_COUNT;
      c.dst = ($urandom_range(99) < 60) ? p.dst : pick_id();
      case ($urandom_range(3))
        0: begin
          c.lo = 32'h0000_0000;
          c.hi = 32'hffff_ffff;
        end
        1: begin
          c.lo = pick_time();
          c.hi = pick_time();
        end
        2: begin
          c.lo = p.ts - 32'($urandom_range(2));
          c.hi = p.ts + 32'($urandom_range(2));
        end
        default: begin
          c.lo = p.ts;
          c.hi = p.ts;
        end
      endcase
    end else if (held_q.size() != 0 && $urandom_range(99) < 20) begin
      c.src = p.src;
      c.dst = p.dst;
      c.ts = p.ts;
    end else begin
      c.src = pick_id();
      c.dst = pick_id();
      c.ts = pick_time();
    end
    return c;
  endfunction

  // leaves valid high after the transfer so back-to-back commands need no second assignment
  task automatic send_cmd(input command_t c, input logic typed, input response_t want);
    response_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.opcode <= c.op;
    cmd_bus.source_id <= c.src;
    cmd_bus.destination <= c.dst;
    cmd_bus.timestamp <= c.ts;
    cmd_bus.start_time <= c.lo;
    cmd_bus.end_time <= c.hi;
    do @(posedge clk); while (!cmd_bus.ready);
    r = advance_buffer(c);
    pending.push_back(typed ? want : r);
  endtask

  task automatic wait_idle();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_reg = v;
  endtask

  task automatic drain_buffer();
    while (held_q.size() != 0) begin
      send_cmd('{OP_FORWARD, 16'($urandom), 16'($urandom), 32'($urandom), 32'($urandom),
                 32'($urandom)}, 1'b0, NONE);
    end
  endtask

  task automatic check_response(input response_t got);
    response_t want;
    responses_seen++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("response %0d with nothing pending: ok=%0b src=%h dst=%h ts=%h cnt=%0d",
                 responses_seen, got.ok, got.src, got.dst, got.ts, got.cnt);
      end
    end else begin
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("response %0d: expected ok=%0b src=%h dst=%h ts=%h cnt=%0d", responses_seen,
                   want.ok, want.src, want.dst, want.ts, want.cnt);
          $display("  got ok=%0b src=%h dst=%h ts=%h cnt=%0d", got.ok, got.src, got.dst,
                   got.ts, got.cnt);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        check_response('{rsp_bus.ok, rsp_bus.out_source, rsp_bus.out_destination,
                         rsp_bus.out_timestamp, rsp_bus.match_count});
      end
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    logic [LIMIT_W-1:0] limits [8];
    int unsigned send_idle [4];
    int unsigned recv_stall [4];
    int unsigned fwd_pct;
    limits = '{7'd127, 7'd2, 7'd64, 7'd1, 7'd0, 7'd5, 7'd64, 7'd3};
    limits[6] = 7'($urandom_range(64, 1));
    send_idle = '{0, 62, 0, 30};
    recv_stall = '{0, 0, 62, 30};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    responses_seen = 0;
    limit_reg = LIMIT_RESET;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    cmd_bus.valid <= 1'b0;
    cmd_bus.opcode <= OP_ADD;
    cmd_bus.source_id <= '0;
    cmd_bus.destination <= '0;
    cmd_bus.timestamp <= '0;
    cmd_bus.start_time <= '0;
    cmd_bus.end_time <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_LIMIT) begin
        set_limit(directed[i].lim);
      end else begin
        send_cmd(directed[i].c, directed[i].typed, directed[i].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle[ph];
      recv_stall_pct = recv_stall[ph];
      for (int sg = 0; sg < 2; sg++) begin
        drain_buffer();
        set_limit(limits[2 * ph + sg]);
        // large limits need few pops so the buffer fills and starts evicting
        fwd_pct = (effective_limit() >= 32) ? 4 : 20;
        repeat (SEG_ITEMS) send_cmd(random_command(fwd_pct), 1'b0, NONE);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ bounded_packet_fifo_dedup_count.f @@
rtl/bpfdc_pkg.sv
rtl/bpfdc_if.sv
rtl/bpfdc_front.sv
rtl/bpfdc_back.sv
rtl/bounded_packet_fifo_dedup_count.sv
bench/testbench.sv
